### rtl/core/tbbt_pkg.sv
// tbbt_pkg: shared types and constants of the tempo / beat / bar tracker
// no dependencies; imported by the channel interfaces, tbbt_core and the top level

package tbbt_pkg;

  localparam int TEMPO_W     = 17;  // tempo in hundredths of bpm
  localparam int RATE_W      = 18;  // sample rate in hz
  localparam int COUNT_W     = 16;  // samples per advance
  localparam int PLAYHEAD_W  = 40;  // playhead in beats, q.8
  localparam int BAR_W       = 32;
  localparam int DIV_W       = 31;  // 6000 * rate fits in 31 bits
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_WDATA_W = 18;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET        = 17'd12000;
  localparam logic [RATE_W-1:0]  RATE_RESET         = 18'd48000;
  localparam logic [TEMPO_W-1:0] FALLBACK_CENTI_BPM = 17'd6000;
  // seconds per minute times hundredths per bpm
  localparam logic [DIV_W-1:0]   RATE_SCALE         = 31'd6000;

  localparam logic OP_REWIND = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEMPO = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE  = 1'b1;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo_centi_bpm;
    logic [RATE_W-1:0]  sample_rate_hz;
  } tbbt_cfg_t;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] sample_count;
  } tbbt_in_t;

  typedef struct packed {
    logic [PLAYHEAD_W-1:0] playhead_beats_q8;
    logic [1:0]            beat_in_bar;
    logic [BAR_W-1:0]      bar_number;
    logic                  beat_started;
    logic                  bar_started;
  } tbbt_out_t;

endpackage

### rtl/core/tbbt_if.sv
// tbbt_in_if / tbbt_out_if: valid-ready channels of the tracker
// depends on tbbt_pkg for the payload structs

interface tbbt_in_if import tbbt_pkg::*; ();
  logic     valid;
  logic     ready;
  tbbt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbbt_out_if import tbbt_pkg::*; ();
  logic      valid;
  logic      ready;
  tbbt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tbbt_alu.sv
// tbbt_alu: the one shared add / subtract unit of the tracker
// depends on nothing; carry out doubles as the a >= b flag when subtracting

module tbbt_alu #(
  parameter int WIDTH = 57
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic [WIDTH:0] full;

  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (WIDTH+1)'(sub);
  assign sum   = full[WIDTH-1:0];
  assign carry = full[WIDTH];

endmodule

### rtl/core/tbbt_core.sv
// tbbt_core: sequencer and datapath registers of the tracker
// depends on tbbt_pkg, tbbt_if and tbbt_alu (shift-add multiply, restoring divide)

module tbbt_core import tbbt_pkg::*; #(
  parameter int BEATS_PER_BAR = 4,
  parameter int POSITION_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  tbbt_cfg_t  cfg,
  tbbt_in_if.sink    req,
  tbbt_out_if.source res
);

  localparam int SW   = POSITION_BITS + TEMPO_W;  // product width
  localparam int QW   = POSITION_BITS + 13;       // quotient bits worth computing
  localparam int BW   = QW - 8;                   // whole beats
  localparam int CW   = $clog2(QW);
  localparam int RB   = $clog2(BEATS_PER_BAR);
  localparam int BI_W = $clog2(TEMPO_W);

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_MUL, S_DIV, S_FIN, S_OUT} state_t;

  state_t                   state;
  logic [POSITION_BITS-1:0] pos;
  logic                     started;
  logic [RB-1:0]            prior_beat;
  logic [BAR_W-1:0]         prior_bar;
  logic [COUNT_W-1:0]       count;
  logic [TEMPO_W-1:0]       bpm;
  logic [DIV_W-1:0]         divisor;
  logic [SW-1:0]            acc;
  logic [DIV_W-1:0]         rem;
  logic [QW-1:0]            quo;
  logic [BW-1:0]            bar_sr;
  logic [RB-1:0]            beat;
  logic [CW-1:0]            cnt;
  tbbt_out_t                res_data;

  logic [SW-1:0]    alu_a;
  logic [SW-1:0]    alu_b;
  logic             alu_sub;
  logic [SW-1:0]    alu_sum;
  logic             q_bit;
  logic [DIV_W:0]   div_t;
  logic [DIV_W-1:0] rate_scaled;
  logic [RB:0]      mod_m;
  logic             mod_ge;
  logic [RB:0]      mod_diff;
  logic [RB+1:0]    prior_wide;
  logic [RB+1:0]    beat_wide;
  logic [BAR_W-1:0] bar_sat;
  tbbt_out_t        fin_data;

  tbbt_alu #(.WIDTH(SW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (q_bit)
  );

  assign div_t       = {rem, quo[QW-1]};
  assign rate_scaled = DIV_W'(cfg.sample_rate_hz) * RATE_SCALE;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_ADD: begin
        alu_a = SW'(pos);
        alu_b = SW'(count);
      end
      S_MUL: begin
        // msb-first shift-add over the tempo bits
        alu_a = {acc[SW-2:0], 1'b0};
        alu_b = bpm[cnt[BI_W-1:0]] ? SW'(pos) : '0;
      end
      S_DIV: begin
        alu_a   = SW'(div_t);
        alu_b   = SW'(divisor);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // beats mod BEATS_PER_BAR, one quotient bit per step
  assign mod_m    = {beat, q_bit};
  assign mod_ge   = mod_m >= (RB+1)'(BEATS_PER_BAR);
  assign mod_diff = mod_m - (RB+1)'(BEATS_PER_BAR);

  assign prior_wide = (RB+2)'(prior_beat);
  assign beat_wide  = (RB+2)'(beat);
  assign bar_sat    = (|bar_sr[BW-1:BAR_W]) ? '1 : bar_sr[BAR_W-1:0];

  always_comb begin
    fin_data.playhead_beats_q8 = (|quo[QW-1:PLAYHEAD_W]) ? '1 : quo[PLAYHEAD_W-1:0];
    fin_data.beat_in_bar       = beat_wide[1:0];
    fin_data.bar_number        = bar_sat;
    fin_data.bar_started       = started && (bar_sat != prior_bar);
    fin_data.beat_started      = (started && (beat != prior_beat)) ||
                                 ((beat == '0) && (!started || (bar_sat != prior_bar)));
  end

  assign req.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      started    <= 1'b0;
      prior_beat <= '0;
      prior_bar  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            count   <= req.data.sample_count;
            bpm     <= (cfg.tempo_centi_bpm == '0) ? FALLBACK_CENTI_BPM : cfg.tempo_centi_bpm;
            divisor <= rate_scaled;
            priority if (req.data.op == OP_REWIND) begin
              pos        <= '0;
              started    <= 1'b0;
              prior_beat <= '0;
              prior_bar  <= '0;
              res_data   <= '0;
              state      <= S_OUT;
            end else if (cfg.sample_rate_hz == '0) begin
              // stored beat and bar, playhead and flags zero
              res_data <= {{PLAYHEAD_W{1'b0}}, prior_wide[1:0], prior_bar, 2'b00};
              state    <= S_OUT;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          // saturating position update
          pos   <= alu_sum[POSITION_BITS] ? '1 : alu_sum[POSITION_BITS-1:0];
          acc   <= '0;
          cnt   <= CW'(TEMPO_W - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= alu_sum;
          if (cnt == '0) begin
            // top 12 bits of product<<8 are below the smallest divisor
            rem    <= DIV_W'(alu_sum[SW-1:SW-12]);
            quo    <= {alu_sum[QW-9:0], 8'b0};
            beat   <= '0;
            cnt    <= CW'(QW - 1);
            state  <= S_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          rem <= q_bit ? alu_sum[DIV_W-1:0] : div_t[DIV_W-1:0];
          quo <= {quo[QW-2:0], q_bit};
          if (cnt >= CW'(8)) begin
            beat   <= mod_ge ? mod_diff[RB-1:0] : mod_m[RB-1:0];
            bar_sr <= {bar_sr[BW-2:0], mod_ge};
          end
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          res_data   <= fin_data;
          started    <= 1'b1;
          prior_beat <= beat;
          prior_bar  <= bar_sat;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/tempo_beat_bar_tracker.sv
// tempo_beat_bar_tracker: 4/4 musical transport, top level
// depends on tbbt_pkg, tbbt_if, tbbt_alu and tbbt_core
//
// usage
//   cmd carries one request: op advance (add sample_count to the position) or
//   rewind (clear position, beat, bar). result returns exactly one item per
//   request: playhead in beats (q.8), beat in bar, bar number and the new-beat
//   and new-bar flags. cfg_we / cfg_index / cfg_wdata write the tempo
//   (hundredths of bpm, 0 = 60 bpm) and the sample rate; write only when idle.
//   an advance runs one position add, 17 shift-add multiply steps over the
//   tempo bits and POSITION_BITS + 13 restoring divide steps, all through the
//   one shared adder, then registers the result. rewind and a zero sample rate
//   skip the arithmetic and answer straight from idle.
//   a new request is not taken until the sequencer has handed off the last one.
//   cmd.ready is low while a request is in the sequencer, so one request is
//   at work at a time. the result sits in an output register; the sequencer
//   may take the next request while it waits, and only stalls when a second
//   result is ready and the register is still full.
//   reset (rst, synchronous): tempo 120.00 bpm, 48000 hz, position 0, no beat seen.

module tempo_beat_bar_tracker import tbbt_pkg::*; #(
  parameter int BEATS_PER_BAR = 4,
  parameter int POSITION_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_WDATA_W-1:0] cfg_wdata,
  tbbt_in_if.sink                cmd,
  tbbt_out_if.source             result
);

  tbbt_cfg_t cfg;
  logic      out_valid;
  tbbt_out_t out_data;

  tbbt_out_if core_res ();

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tempo_centi_bpm <= TEMPO_RESET;
      cfg.sample_rate_hz  <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMPO: cfg.tempo_centi_bpm <= cfg_wdata[TEMPO_W-1:0];
        CFG_RATE:  cfg.sample_rate_hz  <= cfg_wdata[RATE_W-1:0];
      endcase
    end
  end

  tbbt_core #(
    .BEATS_PER_BAR (BEATS_PER_BAR),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (cmd),
    .res (core_res)
  );

  // output register
  assign core_res.ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res.valid && core_res.ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid && core_res.ready) begin
      out_data <= core_res.data;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("sequencer still ready right after taking a request");

  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    core_res.valid && core_res.ready |=> result.valid)
    else $error("handed-off result not shown on the output");

  a_no_take_while_offering: assert property (@(posedge clk) disable iff (rst)
    core_res.valid |-> !cmd.ready)
    else $error("sequencer takes a request while offering a result");

endmodule
